/* src/crsfb_pkg.sv */
// Shared types, constants and the CRC-8/DVB-S2 byte update for the CRSF frame builder.
// No dependencies.
`default_nettype none

package crsfb_pkg;

   localparam int MAX_PAYLOAD_DEF = 60;
   localparam logic [7:0] SYNC_ADDR_RESET = 8'hC8;
   localparam logic [7:0] CRC_POLY = 8'hD5;

   localparam int BYTE_W = 8;
   localparam int LEN_W = 6;
   // widest burst: sync, length, type, payload, crc
   localparam int BUNDLE_LEN = 5;
   localparam int BUNDLE_CNT_W = $clog2(BUNDLE_LEN + 1);
   localparam int BUNDLE_IDX_W = $clog2(BUNDLE_LEN);

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              frame_end;
      logic              length_error;
   } entry_type;

   typedef struct packed {
      entry_type [BUNDLE_LEN-1:0] entry;
      logic [BUNDLE_CNT_W-1:0]    count;
   } bundle_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* src/crsfb_serializer.sv */
// Holds one request's burst of result bytes and hands them out one per cycle while rsp_tready is high.
// Depends on crsfb_pkg (bundle_type, entry_type).
`default_nettype none

module crsfb_serializer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire crsfb_pkg::bundle_type load_bundle,
   input  wire logic                  load_en,
   output logic                       load_ready,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [7:0] out_byte
   output logic                       rsp_tlast,   // frame_end
   output logic                       rsp_tuser    // length_error
);
   import crsfb_pkg::*;

   bundle_type              bundle_ff;
   logic [BUNDLE_CNT_W-1:0] left_ff, left_in;
   logic [BUNDLE_IDX_W-1:0] idx_ff, idx_in;
   entry_type               cur;
   logic                    take;

   assign cur        = bundle_ff.entry[idx_ff];
   assign rsp_tvalid = (left_ff != '0);
   assign take       = rsp_tvalid && rsp_tready;
   // a new burst may load while the last byte of the current one goes out
   assign load_ready = (left_ff == '0) || ((left_ff == BUNDLE_CNT_W'(1)) && rsp_tready);
   assign rsp_tdata  = cur.data;
   assign rsp_tlast  = cur.frame_end;
   assign rsp_tuser  = cur.length_error;

   always_comb begin
      left_in = left_ff;
      idx_in  = idx_ff;
      if (load_en) begin
         left_in = load_bundle.count;
         idx_in  = '0;
      end else if (take) begin
         left_in = left_ff - BUNDLE_CNT_W'(1);
         idx_in  = idx_ff + BUNDLE_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         idx_ff  <= '0;
      end else begin
         left_ff <= left_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         bundle_ff <= load_bundle;
      end
   end

   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> left_ff == BUNDLE_CNT_W'(1))
      else $error("frame end flagged before the last byte of a burst");
   a_err_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("length error without frame end");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      load_en |-> load_ready && load_bundle.count != '0)
      else $error("burst loaded over pending bytes or empty");

endmodule

`default_nettype wire

/* src/crsf_frame_builder.sv */
// CRSF frame builder: one result burst per request, one result byte per cycle while rsp_tready is high.
// Latency: first result is valid the cycle after the request is accepted.
// Bursts: each request yields a burst of results (1 or 2 for a
// continuation byte, 4 or 5 for an opening byte, 1 for a zero length); the next request is
// taken in the cycle the previous burst's last byte is taken, so the output port sets the rate.
// Reset: frame state and CRC cleared, sync address back to 0xC8, pending results dropped.
// Depends on crsfb_pkg and crsfb_serializer.
`default_nettype none

module crsf_frame_builder #(
   parameter int MAX_PAYLOAD = crsfb_pkg::MAX_PAYLOAD_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data,  // sync_address
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,    // [5:0] payload_len, [13:6] payload_byte,
                                          // [15:14] zero
   input  wire logic [7:0]  req_tuser,    // [7:0] frame_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,    // [7:0] out_byte
   output logic             rsp_tlast,    // frame_end
   output logic             rsp_tuser     // length_error
);
   import crsfb_pkg::*;

   localparam int LEFT_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [7:0] MAX_LEN8 = 8'(MAX_PAYLOAD);

   logic [7:0]        sync_ff;
   logic              in_frame_ff, in_frame_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic [7:0]        crc_ff, crc_in;

   logic [7:0]        frame_type, payload_byte;
   logic [LEN_W-1:0]  payload_len;
   logic [7:0]        len8, len_sat;
   logic [7:0]        crc_mid, crc_end;
   logic [LEFT_W-1:0] left_mid, left_dec;
   logic              last_byte, accept;
   bundle_type        bundle;

   assign frame_type   = req_tuser;
   assign payload_len  = req_tdata[5:0];
   assign payload_byte = req_tdata[13:6];
   assign accept       = req_tvalid && req_tready;

   always_comb begin
      len8      = {{(8 - LEN_W){1'b0}}, payload_len};
      len_sat   = (len8 > MAX_LEN8) ? MAX_LEN8 : len8;
      crc_mid   = in_frame_ff ? crc_ff : crc8_update(8'h00, frame_type);
      crc_end   = crc8_update(crc_mid, payload_byte);
      left_mid  = in_frame_ff ? left_ff : len_sat[LEFT_W-1:0];
      left_dec  = (left_mid != '0) ? left_mid - LEFT_W'(1) : left_mid;
      last_byte = (left_dec == '0);

      bundle      = '0;
      in_frame_in = in_frame_ff;
      left_in     = left_ff;
      crc_in      = crc_ff;

      if (!in_frame_ff && payload_len == '0) begin
         bundle.entry[0] = '{data: 8'h00, frame_end: 1'b1, length_error: 1'b1};
         bundle.count    = BUNDLE_CNT_W'(1);
      end else begin
         if (!in_frame_ff) begin
            bundle.entry[0] = '{data: sync_ff, frame_end: 1'b0, length_error: 1'b0};
            bundle.entry[1] = '{data: len_sat + 8'd2, frame_end: 1'b0, length_error: 1'b0};
            bundle.entry[2] = '{data: frame_type, frame_end: 1'b0, length_error: 1'b0};
            bundle.entry[3] = '{data: payload_byte, frame_end: 1'b0, length_error: 1'b0};
            bundle.entry[4] = '{data: crc_end, frame_end: 1'b1, length_error: 1'b0};
            bundle.count    = last_byte ? BUNDLE_CNT_W'(5) : BUNDLE_CNT_W'(4);
         end else begin
            bundle.entry[0] = '{data: payload_byte, frame_end: 1'b0, length_error: 1'b0};
            bundle.entry[1] = '{data: crc_end, frame_end: 1'b1, length_error: 1'b0};
            bundle.count    = last_byte ? BUNDLE_CNT_W'(2) : BUNDLE_CNT_W'(1);
         end
         in_frame_in = !last_byte;
         left_in     = left_dec;
         crc_in      = last_byte ? 8'h00 : crc_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff     <= SYNC_ADDR_RESET;
         in_frame_ff <= 1'b0;
         left_ff     <= '0;
         crc_ff      <= 8'h00;
      end else begin
         if (csr_wr_en) begin
            sync_ff <= csr_wr_data;
         end
         if (accept) begin
            in_frame_ff <= in_frame_in;
            left_ff     <= left_in;
            crc_ff      <= crc_in;
         end
      end
   end

   crsfb_serializer u_ser (
      .clock       (clock),
      .reset       (reset),
      .load_bundle (bundle),
      .load_en     (accept),
      .load_ready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   a_frame_has_bytes: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> left_ff != '0)
      else $error("open frame with no payload bytes left");
   a_zero_len_idle: assert property (@(posedge clock) disable iff (reset)
      accept && !in_frame_ff && payload_len == '0 |=> !in_frame_ff && crc_ff == 8'h00)
      else $error("zero length request opened a frame");
   a_idle_crc_clear: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> crc_ff == 8'h00 && left_ff == '0)
      else $error("stale CRC or count while idle");

endmodule

`default_nettype wire
